// ===== design/kda_pkg.sv =====
// Shared types and constants for the key debounce and auto-repeat block.
`default_nettype none
package kda_pkg;

    localparam int TICK_W = 8;
    localparam int KEYS_W = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_UP     = 2'd1,
        KIND_DOWN   = 2'd2,
        KIND_REPEAT = 2'd3
    } kda_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE_TICKS = 2'd0,
        REG_START_REPEAT = 2'd1,
        REG_NEXT_REPEAT  = 2'd2
    } kda_reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] start_repeat;
        logic [TICK_W-1:0] next_repeat;
    } kda_cfg_t;

    // What one cell reports for the request being accepted
    typedef struct packed {
        logic      active;
        kda_kind_t kind;
    } kda_cell_res_t;

    typedef struct packed {
        logic      key;
        kda_kind_t kind;
    } kda_result_t;

endpackage
`default_nettype wire

// ===== design/key_debounce_autorepeat_top.sv =====
// Top level of the key debounce and auto-repeat block.
//
//  channel  | ports                    | tdata bits (low to high)
//  ---------+--------------------------+---------------------------------------------
//  poll in  | s_tvalid/s_tready/s_tdata| [7:0] tick_now, [9:8] keys_pressed, 0 pad
//  event out| m_tvalid/m_tready/m_tdata| [1:0] event_kind, [2] event_key, 0 pad
//  config   | cfg_wr_en/cfg_index/wdata| 0 settle_ticks, 1 start_repeat, 2 next_repeat
//
// One poll request per cycle while s_tready is high; its event is registered in the buffer.
// A token ring through the key cells picks the polled key, so one cell updates per poll.
// A two-entry output buffer parks a result in its skid entry while the consumer stalls;
// s_tready drops only while both buffer entries are full.
// Reset clears all key state and the registers to their defaults; the first poll sees key 1.
`default_nettype none
module key_debounce_autorepeat_top #(
    parameter int NUM_KEYS = 2
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // tick_now, keys_pressed
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // event_kind, event_key
    input  wire logic                          cfg_wr_en,
    input  wire logic [kda_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kda_pkg::TICK_W-1:0]    cfg_wdata
);
    import kda_pkg::*;

    kda_cfg_t          cfg_reg;
    logic              accept;
    logic [TICK_W-1:0] tick_now;
    logic [KEYS_W-1:0] keys_pressed;
    logic [NUM_KEYS-1:0] token;
    kda_cell_res_t     res [NUM_KEYS];
    logic [NUM_KEYS-1:0] key_bits;
    kda_result_t       result;
    kda_result_t       out_res;

    assign accept       = s_tvalid && s_tready;
    assign tick_now     = s_tdata[TICK_W-1:0];
    assign keys_pressed = s_tdata[TICK_W+KEYS_W-1:TICK_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks <= 8'd10;
            cfg_reg.start_repeat <= 8'hff;
            cfg_reg.next_repeat  <= 8'h20;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_wdata;
                REG_START_REPEAT: cfg_reg.start_repeat <= cfg_wdata;
                REG_NEXT_REPEAT:  cfg_reg.next_repeat  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_cell
        logic lvl;
        if (k < KEYS_W) begin : g_pin
            assign lvl = keys_pressed[k];
        end else begin : g_nopin
            assign lvl = 1'b0;
        end

        kda_cell #(
            .TOKEN_INIT(k == 0)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (accept),
            .token_in (token[(k + NUM_KEYS - 1) % NUM_KEYS]),
            .token_out(token[k]),
            .tick_now (tick_now),
            .level    (lvl),
            .cfg      (cfg_reg),
            .res      (res[k])
        );

        assign key_bits[k] = res[k].active && (res[k].kind != KIND_NONE) && 1'(k);
    end

    always_comb begin
        result.kind = KIND_NONE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            result.kind = kda_kind_t'(result.kind | (res[k].active ? res[k].kind : KIND_NONE));
        end
        result.key = |key_bits;
    end

    kda_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_data(result),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_res)
    );

    assign m_tdata = {5'd0, out_res.key, out_res.kind};

endmodule
`default_nettype wire

// ===== design/kda_cell.sv =====
// One key cell: debounce and repeat state of a single key plus its share of the poll token.
`default_nettype none
module kda_cell #(
    parameter bit TOKEN_INIT = 1'b0
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic                       token_in,
    output logic                            token_out,
    input  wire logic [kda_pkg::TICK_W-1:0] tick_now,
    input  wire logic                       level,
    input  wire kda_pkg::kda_cfg_t          cfg,
    output kda_pkg::kda_cell_res_t          res
);
    import kda_pkg::*;

    logic              token_reg, token_next;
    logic              stable_reg, stable_next;
    logic [TICK_W-1:0] last_reg, last_next;
    logic [TICK_W-1:0] due_reg, due_next;
    logic [TICK_W-1:0] elapsed;
    kda_kind_t         kind;

    assign elapsed   = tick_now - last_reg;
    assign token_out = token_reg;

    always_comb begin
        token_next  = advance ? token_in : token_reg;
        stable_next = stable_reg;
        last_next   = last_reg;
        due_next    = due_reg;
        kind        = KIND_NONE;
        // The cell receiving the token owns this request
        if (token_in) begin
            if (level == stable_reg) begin
                last_next = tick_now;
                if (level && tick_now == due_reg) begin
                    due_next = tick_now + cfg.next_repeat;
                    kind     = KIND_REPEAT;
                end
            end else if (elapsed >= cfg.settle_ticks) begin
                stable_next = level;
                last_next   = tick_now;
                due_next    = tick_now + cfg.start_repeat;
                kind        = level ? KIND_DOWN : KIND_UP;
            end
        end
        res.active = token_in;
        res.kind   = kind;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg  <= TOKEN_INIT;
            stable_reg <= 1'b0;
            last_reg   <= '0;
            due_reg    <= '0;
        end else begin
            token_reg <= token_next;
            if (advance) begin
                stable_reg <= stable_next;
                last_reg   <= last_next;
                due_reg    <= due_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/kda_outbuf.sv =====
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module kda_outbuf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire kda_pkg::kda_result_t push_data,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output kda_pkg::kda_result_t      out_data
);
    import kda_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    kda_result_t out_data_reg, out_data_next;
    kda_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                // Park the result while the consumer stalls
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
`default_nettype wire

// ===== design/kda_checker.sv =====
// Port-level checks for the key debounce block, bound to the top level.
`default_nettype none
module kda_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled event changed");

    a_no_key_without_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == 2'd0 |-> !m_tdata[2])
        else $error("event_key set on an empty event");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("padding bits not zero");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("event valid right after reset");

    a_poll_yields_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted poll produced no event");

endmodule

bind key_debounce_autorepeat_top kda_checker u_kda_checker (.*);
`default_nettype wire
